>>> src/pngunf_pkg.sv
// Shared constants and types for the PNG scanline unfilter block.
`timescale 1ns / 1ps

package pngunf_pkg;

   // Default sizes for the top-level parameters.
   localparam int DEF_MAX_ROW_BYTES   = 8192;
   localparam int DEF_MAX_PIXEL_BYTES = 8;

   // Control register indexes and their widths.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS      = 2'd2;

   // Register widths and reset values.
   localparam int BPP_W  = 4;
   localparam int RB_W   = 14;
   localparam int ROWS_W = 16;
   localparam logic [BPP_W-1:0]  RST_BYTES_PER_PIXEL = 4'd4;
   localparam logic [RB_W-1:0]   RST_ROW_BYTES       = 14'd4;
   localparam logic [ROWS_W-1:0] RST_IMAGE_ROWS      = 16'd1;

   // Largest filter type code that is legal in the stream.
   localparam logic [7:0] FILT_MAX_CODE = 8'd4;

   // PNG filter types.
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filt_type;

endpackage

>>> src/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter: row sequencing, line buffer and output register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// req      in         req_tvalid / req_tready  tdata[7:0] data_byte
// rsp      out        rsp_tvalid / rsp_tready  tdata[7:0] pixel_byte, tlast row_end,
//                                              tuser[0] image_end, tuser[1] bad_filter
// csr      in         csr_valid / csr_ready    csr_index, csr_wdata (always ready)
//
// The block takes one byte in every cycle while its results are taken. A byte is accepted
// into an input stage together with the line buffer entry above it; from that stage it is
// reconstructed and loaded into the output register, where its result becomes valid.
// The line buffer read port and the reconstruction set this rate.
// Reset is synchronous and puts the block at the start of an image, waiting for a filter
// byte. The line buffer needs no clearing pass: the first row of an image never uses it.
// When the output register is full and not taken, the input stage holds and req_tready
// drops only once that stage is also occupied by a byte that produces a result.

module png_scanline_unfilter #(
   parameter int MAX_ROW_BYTES   = pngunf_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_PIXEL_BYTES = pngunf_pkg::DEF_MAX_PIXEL_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] data_byte
   // Result stream.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] pixel_byte
   output logic                              rsp_tlast,
   output logic [1:0]                        rsp_tuser,   // [0] image_end, [1] bad_filter
   // Control register writes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pngunf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pngunf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int CMP_W  = (POS_W > pngunf_pkg::RB_W) ? POS_W : pngunf_pkg::RB_W;
   localparam int HSEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

   // Everything the reconstruction cycle needs to know about one accepted byte.
   typedef struct packed {
      logic [7:0]           data;
      logic                 is_filt;
      logic                 bad;
      pngunf_pkg::filt_type kind;
      logic                 first;
      logic                 row_done;
      logic                 img_done;
      logic [ADDR_W-1:0]    addr;
   } stage_type;

   // Control registers.
   logic [pngunf_pkg::BPP_W-1:0]  bpp_ff;
   logic [pngunf_pkg::RB_W-1:0]   row_bytes_ff;
   logic [pngunf_pkg::ROWS_W-1:0] image_rows_ff;

   // Row sequencing state.
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [pngunf_pkg::ROWS_W-1:0]  row_cnt_ff, row_cnt_in;
   logic                           first_row_ff, first_row_in;
   pngunf_pkg::filt_type           kind_ff, kind_in;

   // Input stage.
   logic                           s_vld_ff, s_vld_in;
   stage_type                      s_ff, s_in;
   logic [7:0]                     up_rd_ff;

   // Pixel histories and line buffer.
   logic [7:0] left_hist_ff [MAX_PIXEL_BYTES];
   logic [7:0] ul_hist_ff   [MAX_PIXEL_BYTES];
   logic [7:0] line_mem     [MAX_ROW_BYTES];

   // Output register.
   logic       rsp_vld_ff, rsp_vld_in;
   logic [7:0] rsp_pix_ff;
   logic       rsp_last_ff;
   logic [1:0] rsp_user_ff;

   logic                          req_acc;
   logic                          at_filt;
   logic [CMP_W-1:0]              rb_ext;
   logic [CMP_W-1:0]              rb_clamp;
   logic [POS_W-1:0]              rb_eff;
   logic [POS_W-1:0]              pos_m1;
   logic [pngunf_pkg::ROWS_W-1:0] rows_eff;
   logic                          rows_hit;
   logic [pngunf_pkg::BPP_W-1:0]  bpp_clamp;
   logic [HSEL_W-1:0]             hist_sel;
   logic [7:0]                    a_byte;
   logic [7:0]                    b_byte;
   logic [7:0]                    c_byte;
   logic [7:0]                    pred;
   logic [7:0]                    rec;
   logic                          emits;
   logic                          s_go;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= pngunf_pkg::RST_BYTES_PER_PIXEL;
         row_bytes_ff  <= pngunf_pkg::RST_ROW_BYTES;
         image_rows_ff <= pngunf_pkg::RST_IMAGE_ROWS;
      end else if (csr_valid) begin
         case (csr_index)
            pngunf_pkg::CSR_BYTES_PER_PIXEL:
               bpp_ff <= csr_wdata[pngunf_pkg::BPP_W-1:0];
            pngunf_pkg::CSR_ROW_BYTES:
               row_bytes_ff <= csr_wdata[pngunf_pkg::RB_W-1:0];
            pngunf_pkg::CSR_IMAGE_ROWS:
               image_rows_ff <= csr_wdata[pngunf_pkg::ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Out-of-range register values act as the nearest legal value.
   always_comb begin
      rb_ext = CMP_W'(row_bytes_ff);
      if (rb_ext == '0) begin
         rb_clamp = CMP_W'(1);
      end else if (rb_ext > CMP_W'(MAX_ROW_BYTES)) begin
         rb_clamp = CMP_W'(MAX_ROW_BYTES);
      end else begin
         rb_clamp = rb_ext;
      end
      rb_eff   = POS_W'(rb_clamp);
      rows_eff = (image_rows_ff == '0) ? pngunf_pkg::ROWS_W'(1) : image_rows_ff;
      if (bpp_ff == '0) begin
         bpp_clamp = pngunf_pkg::BPP_W'(1);
      end else if (bpp_ff > pngunf_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
         bpp_clamp = pngunf_pkg::BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         bpp_clamp = bpp_ff;
      end
      hist_sel = HSEL_W'(bpp_clamp - pngunf_pkg::BPP_W'(1));
   end

   // Accept side: classify the byte and advance the row position.
   always_comb begin
      req_acc  = req_tvalid && req_tready;
      at_filt  = (pos_ff == '0);
      pos_m1   = pos_ff - POS_W'(1);
      rows_hit = ({1'b0, row_cnt_ff} + 17'd1) >= {1'b0, rows_eff};

      s_in.data     = req_tdata;
      s_in.is_filt  = at_filt;
      s_in.bad      = at_filt && (req_tdata > pngunf_pkg::FILT_MAX_CODE);
      s_in.kind     = kind_ff;
      s_in.first    = first_row_ff;
      s_in.row_done = !at_filt && (pos_ff >= rb_eff);
      s_in.img_done = s_in.row_done && rows_hit;
      s_in.addr     = ADDR_W'(pos_m1);

      pos_in       = pos_ff;
      row_cnt_in   = row_cnt_ff;
      first_row_in = first_row_ff;
      kind_in      = kind_ff;
      if (req_acc) begin
         if (at_filt) begin
            pos_in  = POS_W'(1);
            kind_in = s_in.bad ? pngunf_pkg::FILT_NONE
                               : pngunf_pkg::filt_type'(req_tdata[2:0]);
         end else if (s_in.row_done) begin
            pos_in = '0;
            if (rows_hit) begin
               row_cnt_in   = '0;
               first_row_in = 1'b1;
            end else begin
               row_cnt_in   = row_cnt_ff + pngunf_pkg::ROWS_W'(1);
               first_row_in = 1'b0;
            end
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   // Reconstruction side: predict, add, and decide whether the stage can move on.
   assign a_byte = left_hist_ff[hist_sel];
   assign c_byte = ul_hist_ff[hist_sel];
   assign b_byte = s_ff.first ? 8'd0 : up_rd_ff;

   pngunf_predict u_predict (
      .kind         (s_ff.kind),
      .left_byte    (a_byte),
      .up_byte      (b_byte),
      .up_left_byte (c_byte),
      .pred_byte    (pred)
   );

   always_comb begin
      rec        = s_ff.data + pred;
      emits      = !s_ff.is_filt || s_ff.bad;
      s_go       = s_vld_ff && (!emits || !rsp_vld_ff || rsp_tready);
      req_tready = !s_vld_ff || s_go;
      if (req_acc) begin
         s_vld_in = 1'b1;
      end else if (s_go) begin
         s_vld_in = 1'b0;
      end else begin
         s_vld_in = s_vld_ff;
      end
      if (s_go && emits) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         row_cnt_ff   <= '0;
         first_row_ff <= 1'b1;
         kind_ff      <= pngunf_pkg::FILT_NONE;
         s_vld_ff     <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         row_cnt_ff   <= row_cnt_in;
         first_row_ff <= first_row_in;
         kind_ff      <= kind_in;
         s_vld_ff     <= s_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   // Stage payload and line buffer read captured on accept; pixel results written back.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s_ff     <= s_in;
         up_rd_ff <= line_mem[s_in.addr];
      end
      if (s_go && !s_ff.is_filt) begin
         line_mem[s_ff.addr] <= rec;
      end
   end

   // A filter byte clears both histories; each pixel shifts in its result and its upper byte.
   always_ff @(posedge clock) begin
      if (s_go) begin
         if (s_ff.is_filt) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
               left_hist_ff[i] <= 8'd0;
               ul_hist_ff[i]   <= 8'd0;
            end
         end else begin
            left_hist_ff[0] <= rec;
            ul_hist_ff[0]   <= b_byte;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
               left_hist_ff[i] <= left_hist_ff[i-1];
               ul_hist_ff[i]   <= ul_hist_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s_go && emits) begin
         rsp_pix_ff  <= s_ff.bad ? 8'd0 : rec;
         rsp_last_ff <= !s_ff.is_filt && s_ff.row_done;
         rsp_user_ff <= {s_ff.bad, !s_ff.is_filt && s_ff.img_done};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> src/pngunf_predict.sv
// Predictor for the five PNG filter types, including the Paeth selection.
`timescale 1ns / 1ps

module pngunf_predict (
   input  pngunf_pkg::filt_type kind,
   input  logic [7:0]           left_byte,
   input  logic [7:0]           up_byte,
   input  logic [7:0]           up_left_byte,
   output logic [7:0]           pred_byte
);

   logic [8:0] sum_ab;
   logic [8:0] twice_c;
   logic [7:0] dist_a;
   logic [7:0] dist_b;
   logic [8:0] dist_c;
   logic [7:0] paeth;

   // With p = a + b - c: |p - a| = |b - c|, |p - b| = |a - c|, |p - c| = |a + b - 2c|.
   always_comb begin
      sum_ab  = {1'b0, left_byte} + {1'b0, up_byte};
      twice_c = {up_left_byte, 1'b0};
      dist_a  = (up_byte > up_left_byte) ? (up_byte - up_left_byte)
                                         : (up_left_byte - up_byte);
      dist_b  = (left_byte > up_left_byte) ? (left_byte - up_left_byte)
                                           : (up_left_byte - left_byte);
      dist_c  = (sum_ab > twice_c) ? (sum_ab - twice_c) : (twice_c - sum_ab);
      if (({1'b0, dist_a} <= {1'b0, dist_b}) && ({1'b0, dist_a} <= dist_c)) begin
         paeth = left_byte;
      end else if ({1'b0, dist_b} <= dist_c) begin
         paeth = up_byte;
      end else begin
         paeth = up_left_byte;
      end
   end

   always_comb begin
      case (kind)
         pngunf_pkg::FILT_NONE:  pred_byte = 8'd0;
         pngunf_pkg::FILT_SUB:   pred_byte = left_byte;
         pngunf_pkg::FILT_UP:    pred_byte = up_byte;
         pngunf_pkg::FILT_AVG:   pred_byte = sum_ab[8:1];
         pngunf_pkg::FILT_PAETH: pred_byte = paeth;
         default:                pred_byte = 8'd0;
      endcase
   end

endmodule
